// ===== rtl/core/fisq_pkg.sv =====
package fisq_pkg;

	localparam int RadW       = 64;
	localparam int RootW      = 32;
	localparam int ShW        = 5;
	localparam int DivBits    = 2;
	localparam int DivStages  = RadW / DivBits;
	localparam int IterWide   = 5;
	localparam int IterNarrow = 3;

	localparam logic [15:0] SeedNarrowBias = 16'h8000;
	localparam logic [31:0] SeedWideBias   = 32'h8000_0000;

	// one item as it moves down the Newton chain
	typedef struct packed {
		logic              vld;
		logic              narrow;
		logic              zero;
		logic [ShW-1:0]    sh;
		logic [RadW-1:0]   half;
		logic [RootW-1:0]  est;
	} item_t;

	// divider stage: item plus partial remainder, dividend bits left, quotient so far
	typedef struct packed {
		item_t             itm;
		logic [RootW-1:0]  rem;
		logic [RadW-1:0]   dvd;
		logic [RootW-1:0]  quo;
	} div_t;

	// normalising shift in bit pairs: half the leading-zero count of a 32-bit word
	function automatic logic [ShW-1:0] pair_shift(input logic [31:0] w);
		logic [5:0] n;
		logic       found;
		n     = '0;
		found = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!found) begin
				if (w[i]) found = 1'b1;
				else      n = n + 6'd1;
			end
		end
		return n[5:1];
	endfunction

	// one restoring division step: {quotient bit, new remainder}
	function automatic logic [RootW:0] div_step(input logic [RootW-1:0] rem,
			input logic nb, input logic [RootW-1:0] dvs);
		logic [RootW:0] r;
		r = {rem, nb};
		if (r >= {1'b0, dvs}) begin
			r = r - {1'b0, dvs};
			return {1'b1, r[RootW-1:0]};
		end
		return {1'b0, r[RootW-1:0]};
	endfunction

endpackage

// ===== rtl/core/fisq_req_if.sv =====
interface fisq_req_if;
	import fisq_pkg::*;
	logic            valid;
	logic            ready;
	logic [RadW-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

// ===== rtl/core/fisq_rsp_if.sv =====
interface fisq_rsp_if;
	import fisq_pkg::*;
	logic             valid;
	logic             ready;
	logic [RootW-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink   (input valid, input root, output ready);
endinterface

// ===== rtl/core/fisq_iter.sv =====
module fisq_iter
	import fisq_pkg::*;
#(
	parameter int ITER = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  item_t in_item,
	output item_t out_item
);

	localparam logic NarrowAct = (ITER < IterNarrow);

	div_t pipe_s [DivStages];
	div_t nxt    [DivStages];
	div_t head;
	item_t out_s;

	// divider entry: remainder clear, dividend is the halved value
	always_comb begin
		head.itm = in_item;
		head.rem = '0;
		head.dvd = in_item.half;
		head.quo = '0;
	end

	// restoring divider, two quotient bits per stage
	for (genvar j = 0; j < DivStages; j++) begin : g_div
		div_t             prv;
		logic [RootW-1:0] dvs;
		logic [RootW:0]   t;
		assign prv = (j == 0) ? head : pipe_s[(j == 0) ? 0 : j - 1];
		always_comb begin
			nxt[j] = prv;
			dvs = prv.itm.narrow ? {16'b0, prv.itm.est[15:0]} : prv.itm.est;
			for (int b = 0; b < DivBits; b++) begin
				t = div_step(nxt[j].rem, nxt[j].dvd[RadW-1], dvs);
				nxt[j].rem = t[RootW-1:0];
				nxt[j].quo = {nxt[j].quo[RootW-2:0], t[RootW]};
				nxt[j].dvd = {nxt[j].dvd[RadW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) pipe_s[j] <= '0;
			else if (adv) pipe_s[j] <= nxt[j];
		end
	end

	// Newton update with overflow skip (narrow, first three iterations only) and zero divisor (wide)
	div_t        lst;
	logic        skip;
	logic [15:0] qn;
	logic [15:0] estn;
	logic [31:0] qw;
	logic [31:0] estw;
	item_t       upd;
	assign lst = pipe_s[DivStages-1];
	always_comb begin
		skip = lst.itm.half[31:16] >= lst.itm.est[15:0];
		qn   = skip ? lst.itm.half[15:0] : lst.quo[15:0];
		estn = {1'b0, lst.itm.est[15:1]} + qn;
		qw   = (lst.itm.est == '0) ? '1 : lst.quo;
		estw = {1'b0, lst.itm.est[31:1]} + qw;
		upd  = lst.itm;
		if (lst.itm.narrow) begin
			if (NarrowAct) upd.est = {16'b0, estn};
		end else begin
			upd.est = estw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_s <= '0;
		else if (adv) out_s <= upd;
	end

	assign out_item = out_s;

`ifndef SYNTH
	a_narrow_est16: assert property (@(posedge clk) disable iff (!arst_n)
		(out_s.vld && out_s.narrow) |-> (out_s.est[31:16] == 16'b0))
		else $error("narrow estimate exceeds 16 bits");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (out_s == $past(out_s)))
		else $error("iteration output changed during stall");
	a_narrow_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(lst.itm.vld && lst.itm.narrow && !skip) |-> (lst.quo[31:16] == 16'b0))
		else $error("narrow quotient exceeds 16 bits");
`endif

endmodule

// ===== rtl/core/fixed_iteration_integer_sqrt_top.sv =====
// Approximate square root of a 64-bit unsigned value (floor, plus or minus one),
// by a fixed number of Newton steps from a seed taken from the normalised input.
// Inputs whose upper word is zero take a 16-bit path with three steps, others a
// 32-bit path with five steps of 64/32 division; zero gives zero. One item is
// taken every cycle while the output is taken. The pipeline depth is set by the five
// pipelined restoring dividers (two quotient bits per stage, 32 stages each).
// The whole pipeline stalls together when a result waits.
module fixed_iteration_integer_sqrt_top
	import fisq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	fisq_req_if.sink   req,
	fisq_rsp_if.source rsp
);

	logic             adv;
	logic             rsp_vld_q;
	logic [RootW-1:0] rsp_root_q;

	assign adv       = !rsp_vld_q || rsp.ready;
	assign req.ready = adv;

	// stage 1: capture
	logic            vld_s1;
	logic [RadW-1:0] rad_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			rad_s1 <= '0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			rad_s1 <= req.radicand;
		end
	end

	// stage 2: path choice and pair count
	logic           vld_s2, narrow_s2, zero_s2;
	logic [RadW-1:0] rad_s2;
	logic [ShW-1:0] sh_s2;
	logic           nar1;
	assign nar1 = (rad_s1[63:32] == 32'b0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			narrow_s2 <= 1'b0;
			zero_s2   <= 1'b0;
			rad_s2    <= '0;
			sh_s2     <= '0;
		end else if (adv) begin
			vld_s2    <= vld_s1;
			narrow_s2 <= nar1;
			zero_s2   <= (rad_s1 == '0);
			rad_s2    <= rad_s1;
			sh_s2     <= pair_shift(nar1 ? rad_s1[31:0] : rad_s1[63:32]);
		end
	end

	// stage 3: normalise, halve and seed
	logic [31:0]     v32;
	logic [RadW-1:0] v64;
	logic [15:0]     sdn;
	item_t           seed, s3;
	always_comb begin
		v32 = rad_s2[31:0] << {sh_s2, 1'b0};
		v64 = rad_s2 << {sh_s2, 1'b0};
		sdn = {1'b0, v32[31:17]} + SeedNarrowBias;
		seed.vld    = vld_s2;
		seed.narrow = narrow_s2;
		seed.zero   = zero_s2;
		seed.sh     = sh_s2;
		if (narrow_s2) begin
			seed.half = {33'b0, v32[31:1]};
			seed.est  = {16'b0, sdn};
		end else begin
			seed.half = {1'b0, v64[63:1]};
			seed.est  = v64[63:33] + SeedWideBias;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s3 <= '0;
		else if (adv) s3 <= seed;
	end

	// Newton chain
	item_t chain [IterWide+1];
	assign chain[0] = s3;
	for (genvar k = 0; k < IterWide; k++) begin : g_iter
		fisq_iter #(.ITER(k)) u_iter (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_item  (chain[k]),
			.out_item (chain[k+1])
		);
	end

	// denormalise and hold the result
	item_t fin;
	assign fin = chain[IterWide];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q  <= 1'b0;
			rsp_root_q <= '0;
		end else if (adv) begin
			rsp_vld_q  <= fin.vld;
			rsp_root_q <= fin.zero ? '0 : (fin.est >> fin.sh);
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.root  = rsp_root_q;

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (rsp_vld_q && !rsp.ready))
		else $error("input stalled without a waiting result");
	a_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fin.vld && fin.zero) |=> (rsp_root_q == '0))
		else $error("zero input gave nonzero root");
	a_wide_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(fin.vld && !fin.narrow) |-> (fin.sh <= ShW'(15)))
		else $error("wide path shift out of range");
`endif

endmodule
